>>> design/distance_vector_route_update_macros.svh
// assertion helpers for the route update block
// the checks assume the enclosing module has aclk and aresetn
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DVRU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dvru: same-cycle check failed");

// next-cycle implication
`define DVRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dvru: next-cycle check failed");

`else

`define DVRU_ASSERT_IMPL(label, ante, cons)

`define DVRU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/dvru_pkg.sv
package dvru_pkg;

    // field widths
    localparam int ID_W        = 6;
    localparam int COST_W      = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ROUTER_ID    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNREACHABLE_COST = 1'd1;

    // request modes
    localparam logic MODE_LINK_WRITE = 1'b0;
    localparam logic MODE_ADVERTISE  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   own_router_id;
        logic [COST_W-1:0] unreachable_cost;
    } cfg_t;

    // classified request as it sits in the queue
    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   neighbour;
        logic [ID_W-1:0]   destination;
        logic [COST_W-1:0] reported_cost;
        logic [COST_W-1:0] in_link_cost;
        logic [COST_W-1:0] out_link_cost;
        logic              n_ok;
        logic              d_ok;
        logic              own_involved;
        logic              same_node;
    } item_t;

    // result, updated in the lowest bit
    typedef struct packed {
        logic              neighbour_age_out;
        logic [ID_W-1:0]   next_hop_out;
        logic [COST_W-1:0] route_cost_out;
        logic              updated;
    } result_t;

endpackage

>>> design/dvru_front.sv
module dvru_front
    import dvru_pkg::*;
#(
    parameter int ROUTER_COUNT = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tuser,
    output logic                  q_valid,
    input  logic                  q_ready,
    output item_t                 q_item
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    item_t          item_in;
    item_t          q_mem_reg [QUEUE_DEPTH];
    logic [QW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QW:0]    count_reg, count_next;
    logic           push, pop;

    // unpack and classify the incoming request
    always_comb begin
        item_in.mode          = s_tuser;
        item_in.neighbour     = s_tdata[5:0];
        item_in.destination   = s_tdata[11:6];
        item_in.reported_cost = s_tdata[19:12];
        item_in.in_link_cost  = s_tdata[27:20];
        item_in.out_link_cost = s_tdata[35:28];
        item_in.n_ok          = 32'(s_tdata[5:0]) < ROUTER_COUNT;
        item_in.d_ok          = 32'(s_tdata[11:6]) < ROUTER_COUNT;
        item_in.own_involved  = (s_tdata[5:0] == cfg.own_router_id)
                             || (s_tdata[11:6] == cfg.own_router_id);
        item_in.same_node     = s_tdata[5:0] == s_tdata[11:6];
    end

    // queue handshake
    assign s_tready = count_reg < (QW+1)'(QUEUE_DEPTH);
    assign q_valid  = count_reg != '0;
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> design/dvru_back.sv
module dvru_back
    import dvru_pkg::*;
#(
    parameter int ROUTER_COUNT = 64
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    q_valid,
    output logic    q_ready,
    input  item_t   q_item,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

`include "distance_vector_route_update_macros.svh"

    localparam int AW = $clog2(ROUTER_COUNT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HOP  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]        state_reg, state_next;
    item_t             item_reg;

    // route and link tables
    logic [COST_W-1:0] rt_cost_mem [ROUTER_COUNT];
    logic [ID_W-1:0]   rt_hop_mem  [ROUTER_COUNT];
    logic [COST_W-1:0] lk_in_mem   [ROUTER_COUNT];
    logic [COST_W-1:0] lk_out_mem  [ROUTER_COUNT];
    logic [ROUTER_COUNT-1:0] rt_valid_reg;
    logic [ROUTER_COUNT-1:0] lk_valid_reg;
    logic [ROUTER_COUNT-1:0] age_reg;

    logic [COST_W-1:0] rt_cost_rd;
    logic [ID_W-1:0]   rt_hop_rd;
    logic [COST_W-1:0] lk_in_rd, lk_out_rd;
    logic [COST_W-1:0] lk_n_in_reg, lk_n_out_reg;

    logic [AW-1:0]     rt_raddr, lk_raddr, d_addr, n_addr;
    logic              rt_re, lk_re;

    logic [COST_W-1:0] lc;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] newc;
    logic              down_n, down_hop, act, take, commit, out_free;
    logic              rt_we, lk_we, age_we, age_wdata;

    logic              m_valid_reg;
    result_t           m_result_reg, result;

    // read addresses: route and neighbour link first, then next hop link
    assign rt_re    = (state_reg == ST_IDLE) && q_valid;
    assign lk_re    = rt_re || (state_reg == ST_HOP);
    assign rt_raddr = AW'(q_item.destination);
    assign lk_raddr = (state_reg == ST_IDLE) ? AW'(q_item.neighbour) : AW'(rt_hop_rd);
    assign d_addr   = AW'(item_reg.destination);
    assign n_addr   = AW'(item_reg.neighbour);
    assign q_ready  = state_reg == ST_IDLE;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_HOP;
                end
            end
            ST_HOP: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request capture and neighbour link hold
    always_ff @(posedge aclk) begin
        if (rt_re) begin
            item_reg <= q_item;
        end
        if (state_reg == ST_HOP) begin
            lk_n_in_reg  <= lk_in_rd;
            lk_n_out_reg <= lk_out_rd;
        end
    end

    // table memories, registered reads, entries not yet written read as zero
    always_ff @(posedge aclk) begin
        if (rt_re) begin
            rt_cost_rd <= rt_valid_reg[rt_raddr] ? rt_cost_mem[rt_raddr] : '0;
            rt_hop_rd  <= rt_valid_reg[rt_raddr] ? rt_hop_mem[rt_raddr] : '0;
        end
        if (lk_re) begin
            lk_in_rd  <= lk_valid_reg[lk_raddr] ? lk_in_mem[lk_raddr] : '0;
            lk_out_rd <= lk_valid_reg[lk_raddr] ? lk_out_mem[lk_raddr] : '0;
        end
        if (rt_we) begin
            rt_cost_mem[d_addr] <= newc;
            rt_hop_mem[d_addr]  <= item_reg.neighbour;
        end
        if (lk_we) begin
            lk_in_mem[n_addr]  <= item_reg.in_link_cost;
            lk_out_mem[n_addr] <= item_reg.out_link_cost;
        end
    end

    // per-entry valid bits and age bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_valid_reg <= '0;
            lk_valid_reg <= '0;
            age_reg      <= '0;
        end else begin
            if (rt_we) begin
                rt_valid_reg[d_addr] <= 1'b1;
            end
            if (lk_we) begin
                lk_valid_reg[n_addr] <= 1'b1;
            end
            if (age_we) begin
                age_reg[n_addr] <= age_wdata;
            end
        end
    end

    // route decision
    always_comb begin
        lc       = (lk_n_in_reg > lk_n_out_reg) ? lk_n_in_reg : lk_n_out_reg;
        sum      = {1'b0, item_reg.reported_cost} + {1'b0, lc};
        if (item_reg.same_node) begin
            newc = lc;
        end else begin
            newc = sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];
        end
        down_n   = (lk_n_in_reg == cfg.unreachable_cost)
                || (lk_n_out_reg == cfg.unreachable_cost);
        down_hop = (lk_in_rd == cfg.unreachable_cost)
                || (lk_out_rd == cfg.unreachable_cost);
        act      = (item_reg.mode == MODE_ADVERTISE) && item_reg.n_ok && item_reg.d_ok
                && !item_reg.own_involved;
        take     = act && !down_n && (down_hop || (rt_cost_rd == '0) || (newc < rt_cost_rd));
    end

    // commit writes together with the result
    assign out_free  = !m_valid_reg || m_ready;
    assign commit    = (state_reg == ST_EXEC) && out_free;
    assign rt_we     = commit && take;
    assign lk_we     = commit && (item_reg.mode == MODE_LINK_WRITE) && item_reg.n_ok;
    assign age_we    = commit && (take || (act && down_n));
    assign age_wdata = take;

    // result fields after the step
    always_comb begin
        result.updated = take;
        if (take) begin
            result.route_cost_out = newc;
            result.next_hop_out   = item_reg.neighbour;
        end else if (item_reg.d_ok) begin
            result.route_cost_out = rt_cost_rd;
            result.next_hop_out   = rt_hop_rd;
        end else begin
            result.route_cost_out = '0;
            result.next_hop_out   = '0;
        end
        if (!item_reg.n_ok) begin
            result.neighbour_age_out = 1'b0;
        end else if (take) begin
            result.neighbour_age_out = 1'b1;
        end else if (act && down_n) begin
            result.neighbour_age_out = 1'b0;
        end else begin
            result.neighbour_age_out = age_reg[n_addr];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_result_reg <= result;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // checks
    `DVRU_ASSERT_NEXT(a_pop_starts_read, (state_reg == ST_IDLE) && q_valid, state_reg == ST_HOP)
    `DVRU_ASSERT_NEXT(a_hop_then_exec, state_reg == ST_HOP, state_reg == ST_EXEC)
    `DVRU_ASSERT_NEXT(a_stall_holds_exec, (state_reg == ST_EXEC) && m_valid_reg && !m_ready, state_reg == ST_EXEC)
    `DVRU_ASSERT_IMPL(a_update_sets_age, m_valid_reg && m_result_reg.updated, m_result_reg.neighbour_age_out)

endmodule

>>> design/distance_vector_route_update.sv
// Distance-vector route table update. Each request is either a link write
// (tuser 0: store the incoming and outgoing cost of one neighbour) or an
// advertisement (tuser 1: neighbour N reports cost C to destination D), and
// every request returns exactly one result with the route of D and the age
// bit of N after the step. Requests enter a two-deep queue, so the input keeps
// accepting while a result waits on the output. In the table engine the route
// entry of D and the link of N are read first, then the link of the current
// next hop through the same link table port, and a last step decides, writes
// back and loads the output register, waiting until the output is free.
// All tables read as zero after reset through per-entry
// valid bits, so there is no clearing pass. Configuration (own_router_id,
// unreachable_cost) should be written only while no request is in flight.
module distance_vector_route_update
    import dvru_pkg::*;
#(
    parameter int ROUTER_COUNT = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // neighbour, destination, reported_cost, in_link_cost, out_link_cost, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic                   s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // updated, route_cost_out, next_hop_out, neighbour_age_out
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    logic    q_valid, q_ready;
    item_t   q_item;
    result_t m_result;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_router_id    <= '0;
            cfg_reg.unreachable_cost <= {COST_W{1'b1}};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OWN_ROUTER_ID:    cfg_reg.own_router_id    <= cfg_data[ID_W-1:0];
                REG_UNREACHABLE_COST: cfg_reg.unreachable_cost <= cfg_data[COST_W-1:0];
                default: ;
            endcase
        end
    end

    // request intake and queue
    dvru_front #(
        .ROUTER_COUNT (ROUTER_COUNT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // table engine and output register
    dvru_back #(
        .ROUTER_COUNT (ROUTER_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = m_result;

endmodule

>>> tb/distance_vector_route_update_tb.sv
`timescale 1ns / 1ps

module distance_vector_route_update_tb;
    import dvru_pkg::*;

    localparam int ROUTERS       = 64;
    localparam int REQ_BODY_W    = 36;
    localparam int IDLE_LIMIT    = 4000;
    localparam int TAIL_CYCLES   = 20;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 126;
    localparam int POOL_SIZE     = 8;

    // request as it travels: mode on tuser, the rest on tdata from nbr up
    typedef struct packed {
        logic              mode;
        logic [COST_W-1:0] out_cost;
        logic [COST_W-1:0] in_cost;
        logic [COST_W-1:0] adv_cost;
        logic [ID_W-1:0]   dst;
        logic [ID_W-1:0]   nbr;
    } request_t;

    typedef struct {
        request_t req;
        bit       typed;
        result_t  want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // mirror of the route and link tables
    logic [COST_W-1:0] dest_cost [ROUTERS];
    logic [ID_W-1:0]   dest_hop  [ROUTERS];
    logic [COST_W-1:0] link_in   [ROUTERS];
    logic [COST_W-1:0] link_out  [ROUTERS];
    logic              nbr_age   [ROUTERS];
    logic [ID_W-1:0]   own_id;
    logic [COST_W-1:0] unreach_cost;

    result_t   route_results_q [$];
    stim_row_t directed_rows [$];
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    int      errors;
    int      idle_cycles = 0;
    int      burst_left;
    int      stall_kind = 0;
    int      stall_span = 0;
    bit      drv_typed;
    result_t drv_want;

    distance_vector_route_update dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit link_is_down(logic [ID_W-1:0] id);
        return link_in[id] == unreach_cost || link_out[id] == unreach_cost;
    endfunction

    // apply one request to the mirrored tables and return the route it reports
    function automatic result_t predict_route_step(request_t r);
        result_t           res;
        logic [ID_W-1:0]   hop;
        logic [COST_W-1:0] lc;
        logic [COST_W:0]   sum;
        logic [COST_W-1:0] cost_new;
        bit                take;
        take = 1'b0;
        if (r.mode == MODE_LINK_WRITE) begin
            link_in[r.nbr]  = r.in_cost;
            link_out[r.nbr] = r.out_cost;
        end else if (r.dst != own_id && r.nbr != own_id) begin
            hop = dest_hop[r.dst];
            lc  = (link_in[r.nbr] > link_out[r.nbr]) ? link_in[r.nbr] : link_out[r.nbr];
            sum = {1'b0, r.adv_cost} + {1'b0, lc};
            if (r.dst == r.nbr) begin
                cost_new = lc;
            end else begin
                cost_new = sum[COST_W] ? '1 : sum[COST_W-1:0];
            end
            // first matching case decides
            if (link_is_down(r.nbr)) begin
                nbr_age[r.nbr] = 1'b0;
            end else begin
                take = link_is_down(hop) || dest_cost[r.dst] == '0 ||
                       cost_new < dest_cost[r.dst];
            end
            if (take) begin
                dest_cost[r.dst] = cost_new;
                dest_hop[r.dst]  = r.nbr;
                nbr_age[r.nbr]   = 1'b1;
            end
        end
        res.updated           = take;
        res.route_cost_out    = dest_cost[r.dst];
        res.next_hop_out      = dest_hop[r.dst];
        res.neighbour_age_out = nbr_age[r.nbr];
        return res;
    endfunction

    function void add_row(logic mode, int n, int d, int c, int lin, int lout,
                          bit typed = 0, int w_upd = 0, int w_cost = 0,
                          int w_hop = 0, int w_age = 0);
        stim_row_t row;
        row.req.mode               = mode;
        row.req.nbr                = ID_W'(n);
        row.req.dst                = ID_W'(d);
        row.req.adv_cost           = COST_W'(c);
        row.req.in_cost            = COST_W'(lin);
        row.req.out_cost           = COST_W'(lout);
        row.typed                  = typed;
        row.want.updated           = 1'(w_upd);
        row.want.route_cost_out    = COST_W'(w_cost);
        row.want.next_hop_out      = ID_W'(w_hop);
        row.want.neighbour_age_out = 1'(w_age);
        directed_rows.push_back(row);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 8) begin
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return ID_W'($urandom);
    endfunction

    function automatic logic [COST_W-1:0] pick_link_cost();
        case ($urandom_range(0, 9))
            0, 1: return unreach_cost;
            2: return '0;
            3: return '1;
            4: return COST_W'($urandom);
            default: return COST_W'($urandom_range(1, 40));
        endcase
    endfunction

    // mostly requests among a small set of routers, some pure noise
    function automatic request_t random_request();
        request_t r;
        if ($urandom_range(0, 9) == 0) begin
            r.mode     = 1'($urandom);
            r.nbr      = ID_W'($urandom);
            r.dst      = ID_W'($urandom);
            r.adv_cost = COST_W'($urandom);
            r.in_cost  = COST_W'($urandom);
            r.out_cost = COST_W'($urandom);
        end else begin
            r.mode     = ($urandom_range(0, 2) == 0) ? MODE_LINK_WRITE : MODE_ADVERTISE;
            r.nbr      = pick_id();
            r.dst      = pick_id();
            r.adv_cost = ($urandom_range(0, 3) == 0) ? COST_W'($urandom)
                                                     : COST_W'($urandom_range(0, 60));
            r.in_cost  = pick_link_cost();
            r.out_cost = pick_link_cost();
        end
        return r;
    endfunction

    // sender: bursts of requests separated by random gaps
    task automatic send_request(request_t r, bit typed, result_t want);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid  <= 1'b1;
        s_tuser   <= r.mode;
        s_tdata   <= IN_TDATA_W'(r[REQ_BODY_W-1:0]);
        drv_typed <= typed;
        drv_want  <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (route_results_q.size() != 0);
    endtask

    task automatic program_router(logic [ID_W-1:0] own, logic [COST_W-1:0] unreach);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_OWN_ROUTER_ID;
        cfg_data  <= CFG_DATA_W'(own);
        @(posedge aclk);
        cfg_index <= REG_UNREACHABLE_COST;
        cfg_data  <= unreach;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        own_id       = own;
        unreach_cost = unreach;
    endtask

    // receiver: spans of always ready, random, mostly stalled and toggling
    always @(posedge aclk) begin
        if (stall_span == 0) begin
            stall_kind <= $urandom_range(0, 3);
            stall_span <= $urandom_range(8, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_kind)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    // predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        request_t acc;
        result_t  want;
        result_t  got;
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (s_tvalid && s_tready) begin
                acc  = request_t'({s_tuser, s_tdata[REQ_BODY_W-1:0]});
                want = predict_route_step(acc);
                route_results_q.push_back(drv_typed ? drv_want : want);
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (route_results_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", m_tdata));
                end else begin
                    want = route_results_q.pop_front();
                    if (got.updated != want.updated)
                        report_mismatch($sformatf("updated %0d, want %0d",
                                                  got.updated, want.updated));
                    if (got.route_cost_out != want.route_cost_out)
                        report_mismatch($sformatf("route cost %0d, want %0d",
                                                  got.route_cost_out, want.route_cost_out));
                    if (got.next_hop_out != want.next_hop_out)
                        report_mismatch($sformatf("next hop %0d, want %0d",
                                                  got.next_hop_out, want.next_hop_out));
                    if (got.neighbour_age_out != want.neighbour_age_out)
                        report_mismatch($sformatf("age %0d, want %0d",
                                                  got.neighbour_age_out,
                                                  want.neighbour_age_out));
                end
            end
        end
    end

    // watchdog on a stalled handshake
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("distance_vector_route_update_tb: errors");
        $finish;
    end

    initial begin
        result_t  none;
        request_t r;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = 1'b0;
        s_tdata    = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_OWN_ROUTER_ID;
        cfg_data   = '0;
        drv_typed  = 1'b0;
        drv_want   = '0;
        errors     = 0;
        burst_left = 0;
        none       = '0;
        own_id       = '0;
        unreach_cost = '1;
        for (int i = 0; i < ROUTERS; i++) begin
            dest_cost[i] = '0;
            dest_hop[i]  = '0;
            link_in[i]   = '0;
            link_out[i]  = '0;
            nbr_age[i]   = 1'b0;
        end

        // directed requests under reset configuration
        //      mode             n   d   c    in   out  typed upd cost hop age
        add_row(MODE_ADVERTISE,  1,  2,  10,  0,   0,   1,    1,  10,  1,  1);
        add_row(MODE_ADVERTISE,  0,  5,  50,  0,   0,   1,    0,  0,   0,  0);
        add_row(MODE_ADVERTISE,  3,  0,  50,  0,   0,   1,    0,  0,   0,  0);
        add_row(MODE_LINK_WRITE, 63, 63, 0,   255, 0,   1,    0,  0,   0,  0);
        add_row(MODE_ADVERTISE,  63, 7,  255, 0,   0,   1,    0,  0,   0,  0);
        add_row(MODE_LINK_WRITE, 4,  4,  0,   200, 100);
        // destination is the neighbour itself
        add_row(MODE_ADVERTISE,  4,  4,  0,   0,   0);
        add_row(MODE_LINK_WRITE, 6,  0,  0,   254, 254);
        // sum saturates at the top cost
        add_row(MODE_ADVERTISE,  6,  10, 255, 0,   0);
        // cheaper route replaces
        add_row(MODE_ADVERTISE,  4,  10, 1,   0,   0);
        // costlier route is kept out
        add_row(MODE_ADVERTISE,  6,  10, 200, 0,   0);
        // next hop goes unreachable, then any route wins
        add_row(MODE_LINK_WRITE, 4,  10, 0,   0,   255);
        add_row(MODE_ADVERTISE,  6,  10, 255, 0,   0);
        // unreachable neighbour loses its age bit
        add_row(MODE_ADVERTISE,  4,  11, 3,   0,   0);
        // zero cost route reads as no route afterwards
        add_row(MODE_ADVERTISE,  62, 63, 0,   0,   0);
        add_row(MODE_ADVERTISE,  61, 63, 5,   0,   0);
        add_row(MODE_LINK_WRITE, 42, 21, 170, 170, 85);
        add_row(MODE_ADVERTISE,  21, 42, 170, 85,  170);
        add_row(MODE_ADVERTISE,  42, 21, 85,  0,   0);
        add_row(MODE_LINK_WRITE, 63, 0,  0,   0,   0);
        add_row(MODE_ADVERTISE,  63, 62, 254, 0,   0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // random phases, each under its own configuration
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            case (ph)
                0: program_router(ID_W'(17), '1);
                1: program_router('1, '0);
                2: program_router('0, COST_W'(30));
                3: program_router(ID_W'($urandom), COST_W'($urandom));
                default: program_router(ID_W'($urandom), COST_W'(254));
            endcase
            for (int i = 0; i < POOL_SIZE; i++)
                id_pool[i] = ID_W'($urandom);
            id_pool[0] = own_id;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // sender holds off until the pipeline is empty
                if (ph == 2 && k == PHASE_ITEMS / 2)
                    drain_results();
                r = random_request();
                send_request(r, 1'b0, none);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (route_results_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", route_results_q.size()));
        if (errors == 0) begin
            $display("distance_vector_route_update_tb: clean");
        end else begin
            $display("distance_vector_route_update_tb: errors");
        end
        $finish;
    end

endmodule
